FILE: rtl/core/dht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hash table package
// Shared types, constants and codes for the hash table engine.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int SLOT_DEPTH = 1024;
  localparam int KEY_BITS   = 32;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);
  localparam int SIZE_W     = 11;
  localparam int PRB_W      = 10;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(5);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(SLOT_DEPTH);

  typedef enum logic [1:0] {
    K_LOOKUP = 2'd0,
    K_INSERT = 2'd1,
    K_REMOVE = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_t;

  typedef struct packed {
    kind_t               kind;
    logic [KEY_BITS-1:0] key;
    logic [SIZE_W-1:0]   size;
    logic [SLOT_W-1:0]   pos;
    logic [SLOT_W-1:0]   step;
  } job_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_RD,
    BS_CHK,
    BS_CLR,
    BS_OUT
  } bstate_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MOD,
    FS_PUSH
  } fstate_t;

endpackage

FILE: rtl/core/double_hash_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hash table engine
// Open-addressing hash table with double hashing and tombstones.
//
//   channel  ports                          beat
//   in       in_valid/in_ready              kind, key, hash
//   out      out_valid/out_ready            status, slot, probes, occupied
//   cfg      cfg_valid/cfg_ready            table size
//
// The front end accepts a request, reduces the hash by the two moduli and
// then hands the job to the queue, waiting while it is full; a clear skips
// the moduli. The probe engine examines each slot through its registered
// memory read. After reset and on every clear, a sweep empties all 1024
// slots of the tag memory. The queue lets the front end reduce the next hash
// while a search runs.
// ----------------------------------------------------------------------------
module double_hash_table_engine import dht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key,
  input  logic [31:0] in_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_slot,
  output logic [9:0]  out_probes,
  output logic [10:0] out_occupied,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_table_size
);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_eff;
  logic              q_push, q_full, q_pop, q_nonempty;
  job_t              q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_table_size;
    end
  end

  assign cfg_ready = 1'b1;
  assign size_eff  = (size_r < SIZE_MIN) ? SIZE_MIN : (size_r > SIZE_MAX) ? SIZE_MAX : size_r;

  dht_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_key, .in_hash,
    .size_eff, .q_push, .q_data(q_in), .q_full
  );

  dht_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .nonempty(q_nonempty)
  );

  dht_back u_back (
    .clk, .rst_n, .q_nonempty, .q_job(q_out), .q_pop,
    .out_valid, .out_ready, .out_status, .out_slot, .out_probes, .out_occupied
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full && !q_pop)) else $error("queue overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty) else $error("pop from empty queue");
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupied <= 11'd1024) else $error("occupancy out of range");
`endif

endmodule

FILE: rtl/core/dht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hash table front end
// Accepts requests and computes the start slot and probe step by restoring
// division, one quotient bit per cycle for both moduli at once.
// ----------------------------------------------------------------------------
module dht_front import dht_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [31:0]         in_key,
  input  logic [31:0]         in_hash,
  input  logic [SIZE_W-1:0]   size_eff,
  output logic                q_push,
  output job_t                q_data,
  input  logic                q_full
);

  fstate_t             st_r, st_nxt;
  logic [31:0]         hash_r, hash_nxt;
  logic [SIZE_W:0]     ra_r, ra_nxt, rb_r, rb_nxt;
  logic [5:0]          bit_r, bit_nxt;
  kind_t               kind_r, kind_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SIZE_W:0]     ta, tb, sb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    hash_r <= hash_nxt;
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
    bit_r  <= bit_nxt;
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    size_r <= size_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    hash_nxt = hash_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    bit_nxt  = bit_r;
    kind_nxt = kind_r;
    key_nxt  = key_r;
    size_nxt = size_r;
    in_ready = 1'b0;
    q_push   = 1'b0;
    sb = {1'b0, size_r} - (SIZE_W+1)'(2);
    ta = {ra_r[SIZE_W-1:0], hash_r[31]};
    tb = {rb_r[SIZE_W-1:0], hash_r[31]};
    q_data.kind = kind_r;
    q_data.key  = key_r;
    q_data.size = size_r;
    q_data.pos  = SLOT_W'(ra_r);
    q_data.step = SLOT_W'(rb_r + (SIZE_W+1)'(1));
    unique case (st_r)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          hash_nxt = in_hash;
          kind_nxt = kind_t'(in_kind);
          key_nxt  = KEY_BITS'(in_key);
          size_nxt = size_eff;
          ra_nxt   = '0;
          rb_nxt   = '0;
          bit_nxt  = '0;
          st_nxt   = (in_kind == K_CLEAR) ? FS_PUSH : FS_MOD;
        end
      end
      FS_MOD: begin
        ra_nxt   = (ta >= {1'b0, size_r}) ? ta - {1'b0, size_r} : ta;
        rb_nxt   = (tb >= sb) ? tb - sb : tb;
        hash_nxt = {hash_r[30:0], 1'b0};
        bit_nxt  = bit_r + 6'd1;
        if (bit_r == 6'd31) begin
          st_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = FS_IDLE;
        end
      end
      default: st_nxt = FS_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/dht_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hash table job queue
// Two-entry queue that decouples the front end from the probe engine.
// ----------------------------------------------------------------------------
module dht_queue import dht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic nonempty
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= din;
  end

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign dout     = mem_r[rp_r];

endmodule

FILE: rtl/core/dht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hash table probe engine
// Walks the probe sequence through the key and tag memories, applies the
// update and holds the result until the output beat is taken. A clearing
// sweep after reset and on clear empties the tag memory one slot a cycle.
// ----------------------------------------------------------------------------
module dht_back import dht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [9:0]        out_slot,
  output logic [9:0]        out_probes,
  output logic [10:0]       out_occupied
);

  logic [KEY_BITS-1:0] keys_m [SLOT_DEPTH];
  tag_t                tags_m [SLOT_DEPTH];

  bstate_t             st_r, st_nxt;
  job_t                job_r, job_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt, tomb_r, tomb_nxt;
  logic                have_r, have_nxt;
  logic [SIZE_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]    ecnt_r, ecnt_nxt, tcnt_r, tcnt_nxt;
  logic [SLOT_W:0]     clr_r, clr_nxt;
  status_t             ost_r, ost_nxt;
  logic [SLOT_W-1:0]   oslot_r, oslot_nxt;
  logic [PRB_W-1:0]    oprb_r, oprb_nxt;
  tag_t                rtag_r;
  logic [KEY_BITS-1:0] rkey_r;
  logic                we;
  logic [SLOT_W-1:0]   waddr;
  tag_t                wtag;
  logic                kwe;
  logic [SLOT_W:0]     padd;
  logic [SLOT_W-1:0]   pnext;
  logic [PRB_W-1:0]    nsat;
  logic                last;
  logic [SIZE_W-1:0]   quarter;
  logic [SIZE_W:0]     thresh;

  always_ff @(posedge clk) begin
    rtag_r <= tags_m[pos_r];
    rkey_r <= keys_m[pos_r];
    if (we) tags_m[waddr] <= wtag;
    if (kwe) keys_m[waddr] <= job_r.key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BS_CLR;
      clr_r  <= '0;
      ecnt_r <= '0;
      tcnt_r <= '0;
      ost_r  <= ST_FOUND;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      ecnt_r <= ecnt_nxt;
      tcnt_r <= tcnt_nxt;
      ost_r  <= ost_nxt;
    end
    job_r   <= job_nxt;
    pos_r   <= pos_nxt;
    tomb_r  <= tomb_nxt;
    have_r  <= have_nxt;
    n_r     <= n_nxt;
    oslot_r <= oslot_nxt;
    oprb_r  <= oprb_nxt;
  end

  always_comb begin
    padd  = {1'b0, pos_r} + {1'b0, job_r.step};
    pnext = (padd >= (SLOT_W+1)'(job_r.size)) ? SLOT_W'(padd - (SLOT_W+1)'(job_r.size))
                                              : SLOT_W'(padd);
    nsat  = (n_r > SIZE_W'(1023)) ? PRB_W'(1023) : PRB_W'(n_r);
    last  = (n_r + SIZE_W'(1)) >= job_r.size;
    quarter = q_job.size >> 2;
    thresh  = {1'b0, quarter} + {quarter, 1'b0};
  end

  always_comb begin
    st_nxt    = st_r;
    job_nxt   = job_r;
    pos_nxt   = pos_r;
    tomb_nxt  = tomb_r;
    have_nxt  = have_r;
    n_nxt     = n_r;
    ecnt_nxt  = ecnt_r;
    tcnt_nxt  = tcnt_r;
    clr_nxt   = clr_r;
    ost_nxt   = ost_r;
    oslot_nxt = oslot_r;
    oprb_nxt  = oprb_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    kwe       = 1'b0;
    waddr     = pos_r;
    wtag      = TAG_LIVE;
    unique case (st_r)
      BS_IDLE: begin
        if (q_nonempty) begin
          q_pop    = 1'b1;
          job_nxt  = q_job;
          pos_nxt  = q_job.pos;
          have_nxt = 1'b0;
          n_nxt    = '0;
          oslot_nxt = '0;
          oprb_nxt  = '0;
          if (q_job.kind == K_CLEAR) begin
            clr_nxt  = '0;
            ecnt_nxt = '0;
            tcnt_nxt = '0;
            ost_nxt  = ST_CLEARED;
            st_nxt   = BS_CLR;
          end else if (q_job.kind == K_INSERT && thresh <= {1'b0, ecnt_r}) begin
            ost_nxt = ST_FULL;
            st_nxt  = BS_OUT;
          end else begin
            st_nxt = BS_RD;
          end
        end
      end
      BS_RD: st_nxt = BS_CHK;
      BS_CHK: begin
        oprb_nxt = nsat;
        if (rtag_r == TAG_EMPTY || (rtag_r == TAG_LIVE && rkey_r == job_r.key)) begin
          oslot_nxt = pos_r;
          st_nxt    = BS_OUT;
          if (rtag_r == TAG_LIVE) begin
            if (job_r.kind == K_REMOVE) begin
              we       = 1'b1;
              wtag     = TAG_TOMB;
              tcnt_nxt = tcnt_r + CNT_W'(1);
              ost_nxt  = ST_REMOVED;
            end else begin
              ost_nxt = ST_FOUND;
            end
          end else if (job_r.kind == K_INSERT) begin
            we      = 1'b1;
            kwe     = 1'b1;
            ost_nxt = ST_INSERTED;
            if (have_r) begin
              waddr     = tomb_r;
              oslot_nxt = tomb_r;
              if (tcnt_r != '0) tcnt_nxt = tcnt_r - CNT_W'(1);
            end else begin
              ecnt_nxt = ecnt_r + CNT_W'(1);
            end
          end else begin
            ost_nxt = ST_NOTFOUND;
          end
        end else begin
          if (rtag_r != TAG_LIVE && !have_r) begin
            have_nxt = 1'b1;
            tomb_nxt = pos_r;
          end
          if (last) begin
            oprb_nxt  = (n_r >= SIZE_W'(1023)) ? PRB_W'(1023) : PRB_W'(n_r + SIZE_W'(1));
            oslot_nxt = pos_r;
            st_nxt    = BS_OUT;
            if (job_r.kind == K_INSERT) begin
              if (have_r || rtag_r != TAG_LIVE) begin
                we        = 1'b1;
                kwe       = 1'b1;
                waddr     = have_r ? tomb_r : pos_r;
                oslot_nxt = waddr;
                ost_nxt   = ST_INSERTED;
                if (tcnt_r != '0) tcnt_nxt = tcnt_r - CNT_W'(1);
              end else begin
                ost_nxt   = ST_FULL;
                oslot_nxt = '0;
                oprb_nxt  = '0;
              end
            end else begin
              ost_nxt = ST_NOTFOUND;
            end
          end else begin
            n_nxt   = n_r + SIZE_W'(1);
            pos_nxt = pnext;
            st_nxt  = BS_RD;
          end
        end
      end
      BS_CLR: begin
        we      = 1'b1;
        waddr   = SLOT_W'(clr_r);
        wtag    = TAG_EMPTY;
        clr_nxt = clr_r + (SLOT_W+1)'(1);
        if (clr_r == (SLOT_W+1)'(SLOT_DEPTH - 1)) begin
          st_nxt = (ost_r == ST_CLEARED && job_r.kind == K_CLEAR) ? BS_OUT : BS_IDLE;
        end
      end
      BS_OUT: begin
        if (out_ready) st_nxt = BS_IDLE;
      end
      default: st_nxt = BS_IDLE;
    endcase
  end

  assign out_valid    = st_r == BS_OUT;
  assign out_status   = ost_r;
  assign out_slot     = 10'(oslot_r);
  assign out_probes   = oprb_r;
  assign out_occupied = 11'(ecnt_r);

endmodule

FILE: dv/tb_double_hash_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hash table engine testbench
// Drives lookup, insert, remove and clear requests through several table
// sizes, keeps a shadow copy of the slot store and checks every result beat.
// ----------------------------------------------------------------------------
module tb_double_hash_table_engine;
  import dht_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [31:0] key;
    logic [31:0] hash;
  } request_t;

  typedef struct {
    status_t     status;
    logic [9:0]  slot;
    logic [9:0]  probes;
    logic [10:0] occupied;
  } answer_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_hash = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [9:0]  out_slot;
  logic [9:0]  out_probes;
  logic [10:0] out_occupied;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_table_size = '0;

  request_t    pending_reqs[$];
  answer_t     expected_answers[$];
  logic [31:0] shadow_keys[SLOT_DEPTH];
  tag_t        shadow_tags[SLOT_DEPTH];
  int unsigned shadow_elements;
  int unsigned shadow_tombs;
  int unsigned shadow_size = 1021;
  logic [31:0] pool_key[64];
  logic [31:0] pool_hash[64];
  int          pool_len;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_request = 1'b0;
  bit          calm;

  double_hash_table_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_key(in_key), .in_hash(in_hash),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot(out_slot),
    .out_probes(out_probes), .out_occupied(out_occupied),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_table_size(cfg_table_size)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  assign calm = (cycle_count >= 30000) && (cycle_count < 70000);

  function automatic answer_t search_table(request_t r);
    answer_t     a;
    int unsigned s, pos, step, n, tomb;
    bit          have_tomb, hit, empty_hit;
    s = shadow_size < 5 ? 5 : (shadow_size > SLOT_DEPTH ? SLOT_DEPTH : shadow_size);
    have_tomb = 0;
    hit = 0;
    empty_hit = 0;
    tomb = 0;
    if (r.kind == K_CLEAR) begin
      for (int i = 0; i < SLOT_DEPTH; i++) shadow_tags[i] = TAG_EMPTY;
      shadow_elements = 0;
      shadow_tombs = 0;
      a = '{ST_CLEARED, 10'd0, 10'd0, 11'd0};
      return a;
    end
    if (r.kind == K_INSERT && (s / 4) <= (shadow_elements / 3)) begin
      a = '{ST_FULL, 10'd0, 10'd0, 11'(shadow_elements)};
      return a;
    end
    pos = r.hash % s;
    step = 1 + r.hash % (s - 2);
    for (n = 0; n < s; n++) begin
      if (shadow_tags[pos] == TAG_EMPTY) begin
        empty_hit = 1;
        break;
      end
      if (shadow_tags[pos] == TAG_LIVE) begin
        if (shadow_keys[pos] == r.key) begin
          hit = 1;
          break;
        end
      end else if (!have_tomb) begin
        have_tomb = 1;
        tomb = pos;
      end
      if (n + 1 < s) begin
        pos += step;
        if (pos >= s) pos -= s;
      end
    end
    if (n > 1023) n = 1023;
    if (hit) begin
      if (r.kind == K_REMOVE) begin
        shadow_tags[pos] = TAG_TOMB;
        shadow_tombs++;
        a.status = ST_REMOVED;
      end else begin
        a.status = ST_FOUND;
      end
      a.slot = 10'(pos);
    end else if (r.kind == K_INSERT) begin
      if (have_tomb) begin
        shadow_keys[tomb] = r.key;
        shadow_tags[tomb] = TAG_LIVE;
        if (shadow_tombs > 0) shadow_tombs--;
        a.status = ST_INSERTED;
        a.slot = 10'(tomb);
      end else if (empty_hit) begin
        shadow_keys[pos] = r.key;
        shadow_tags[pos] = TAG_LIVE;
        shadow_elements++;
        a.status = ST_INSERTED;
        a.slot = 10'(pos);
      end else begin
        a.status = ST_FULL;
        a.slot = '0;
        n = 0;
      end
    end else begin
      a.status = ST_NOTFOUND;
      a.slot = 10'(pos);
    end
    a.probes = 10'(n);
    a.occupied = 11'(shadow_elements);
    return a;
  endfunction

  always @(posedge clk) begin
    request_t r;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        r.kind = kind_t'(in_kind);
        r.key = in_key;
        r.hash = in_hash;
        expected_answers.push_back(search_table(r));
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
          r = pending_reqs.pop_front();
          in_kind <= r.kind;
          in_key <= r.key;
          in_hash <= r.hash;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result beat: status %0d slot %0d", out_status, out_slot);
        fail_count++;
      end else begin
        e = expected_answers.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          fail_count++;
        end
        if (out_slot !== e.slot) begin
          $error("slot: expected %0d, actual %0d", e.slot, out_slot);
          fail_count++;
        end
        if (out_probes !== e.probes) begin
          $error("probes: expected %0d, actual %0d", e.probes, out_probes);
          fail_count++;
        end
        if (out_occupied !== e.occupied) begin
          $error("occupied: expected %0d, actual %0d", e.occupied, out_occupied);
          fail_count++;
        end
      end
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(0, 99) >= 6;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(kind_t k, logic [31:0] key, logic [31:0] hash);
    request_t r;
    r.kind = k;
    r.key = key;
    r.hash = hash;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_answers.size() != 0 || in_valid)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_size(logic [10:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_table_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_size = value;
  endtask

  task automatic random_phase(int count, int pool_size);
    int pick, roll;
    pool_len = pool_size;
    for (int i = 0; i < pool_len; i++) begin
      pool_key[i] = $urandom();
      pool_hash[i] = $urandom();
    end
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, pool_len - 1);
      if (roll < 8) begin
        queue_req(kind_t'($urandom_range(0, 2)), $urandom(), $urandom());
      end else if (roll < 9) begin
        queue_req(K_CLEAR, $urandom(), $urandom());
      end else if (roll < 44) begin
        queue_req(K_LOOKUP, pool_key[pick], pool_hash[pick]);
      end else if (roll < 78) begin
        queue_req(K_INSERT, pool_key[pick], pool_hash[pick]);
      end else begin
        queue_req(K_REMOVE, pool_key[pick], pool_hash[pick]);
      end
      if (pending_reqs.size() > 50) @(negedge clk);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      shadow_tags[i] = TAG_EMPTY;
      shadow_keys[i] = '0;
    end
    shadow_elements = 0;
    shadow_tombs = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_req(K_LOOKUP, 32'h0, 32'h0);
    queue_req(K_INSERT, 32'h0, 32'h0);
    queue_req(K_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(K_INSERT, 32'h1234_5678, 32'd1021);
    queue_req(K_INSERT, 32'h0BAD_F00D, 32'd2042);
    queue_req(K_LOOKUP, 32'h0BAD_F00D, 32'd2042);
    queue_req(K_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(K_REMOVE, 32'h1234_5678, 32'd1021);
    queue_req(K_LOOKUP, 32'h0BAD_F00D, 32'd2042);
    queue_req(K_REMOVE, 32'hDEAD_BEEF, 32'd1021);
    queue_req(K_INSERT, 32'hDEAD_BEEF, 32'd3063);
    queue_req(K_INSERT, 32'h0, 32'h0);
    queue_req(K_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(K_LOOKUP, 32'h0, 32'h0);

    write_size(11'd5);
    for (int i = 0; i < 4; i++) queue_req(K_INSERT, 32'(i + 7), 32'(i * 3));
    queue_req(K_REMOVE, 32'd7, 32'd0);
    queue_req(K_INSERT, 32'd7, 32'd0);
    random_phase(120, 6);

    write_size(11'd13);
    queue_req(K_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < 12; i++) queue_req(K_INSERT, 32'(100 + i), 32'(i * 5 + 1));
    write_size(11'd5);
    for (int i = 0; i < 6; i++) queue_req(K_LOOKUP, 32'(900 + i), 32'(i * 7));
    queue_req(K_REMOVE, 32'd999, 32'd2);
    queue_req(K_INSERT, 32'd998, 32'd3);
    random_phase(100, 12);

    write_size(11'd7);
    random_phase(150, 8);
    hold_request = 1'b1;
    write_size(11'd2047);
    random_phase(180, 64);
    write_size(11'd0);
    random_phase(150, 8);
    write_size(11'd1021);
    random_phase(200, 64);
    write_size(11'd8);
    random_phase(150, 10);
    write_size(11'd11);
    random_phase(180, 12);
    write_size(11'd31);
    random_phase(200, 36);
    write_size(11'd97);
    random_phase(200, 64);
    write_size(11'd1024);
    random_phase(150, 64);
    write_size(11'd13);
    random_phase(150, 16);

    wait_idle();
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dht_pkg.sv
rtl/core/dht_front.sv
rtl/core/dht_queue.sv
rtl/core/dht_back.sv
rtl/core/double_hash_table_engine.sv
dv/tb_double_hash_table_engine.sv
